/* rtl/cddy_pkg.sv */
// Shared types, constants and register codes for the y-derivative block.
`timescale 1ns / 1ps
`default_nettype none
package cddy_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int MAX_POINTS_DEF = 1024;
    localparam int FRAC_BITS      = 16;
    localparam int SPACING_W      = 32;
    localparam int IDX_W          = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 11;
    localparam int SIZE_W         = 11;
    localparam int GUARD_W        = 3;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_METHOD       = 3'd0,
        REG_POINTS       = 3'd1,
        REG_Y_GUARD      = 3'd2,
        REG_COLUMN_COUNT = 3'd3,
        REG_X_GUARD      = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'd0,
        DIV_RUN  = 2'd1,
        DIV_DONE = 2'd2
    } div_state_t;
endpackage
`default_nettype wire

/* rtl/central_difference_derivative_y_core.sv */
// Top level of the streaming central-difference y-derivative.
//  channel | handshake        | payload
//  input   | push / full      | sample, spacing
//  result  | empty / pop      | derivative, x_index, y_index, overflow
//  config  | cfg_valid/ready  | cfg_index, cfg_data
// The front end takes one item per cycle while the work queue has room.
// Each interior point passes through the bit-serial divider, which takes one
// point at a time and sets the sustained rate for points that produce a result.
// Guard points produce no result. The four-entry output queue lets results wait.
// Reset clears counters, window, queues and configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module central_difference_derivative_y_core #(
    parameter int DATA_WIDTH = cddy_pkg::DATA_WIDTH_DEF,
    parameter int MAX_POINTS = cddy_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic signed [DATA_WIDTH-1:0]           sample,
    input  wire logic [cddy_pkg::SPACING_W-1:0]         spacing,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed [DATA_WIDTH-1:0]                derivative,
    output logic [cddy_pkg::IDX_W-1:0]                  x_index,
    output logic [cddy_pkg::IDX_W-1:0]                  y_index,
    output logic                                        overflow,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [cddy_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [cddy_pkg::CFG_DATA_W-1:0]        cfg_data
);
    localparam int NUM_W = DATA_WIDTH + 5;
    localparam int WQ_W  = NUM_W + 1 + cddy_pkg::SPACING_W + 2 * cddy_pkg::IDX_W;
    localparam int RQ_W  = DATA_WIDTH + 1 + 2 * cddy_pkg::IDX_W;
    localparam int CW    = $clog2(cddy_pkg::QUEUE_DEPTH) + 1;

    logic                             method_reg;
    logic [cddy_pkg::SIZE_W-1:0]      ppc_reg, cols_reg;
    logic [cddy_pkg::GUARD_W-1:0]     yg_reg, xg_reg;
    logic                             accept, f_emit, f_method;
    logic signed [NUM_W-1:0]          f_num;
    logic [cddy_pkg::SPACING_W-1:0]   f_dy;
    logic [cddy_pkg::IDX_W-1:0]       f_x, f_y;
    logic [WQ_W-1:0]                  wq_out;
    logic                             wq_ne, start, busy, done, b_ovf, take;
    logic [CW-1:0]                    wq_cnt, rq_cnt;
    logic signed [DATA_WIDTH-1:0]     b_res;
    logic [RQ_W-1:0]                  rq_out;
    logic                             rq_ne;
    logic [cddy_pkg::IDX_W-1:0]       bx_reg, by_reg;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    // room for the item in the pipe register plus the one being pushed
    assign full      = wq_cnt >= CW'(cddy_pkg::QUEUE_DEPTH - 1);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= 1'b0;
            ppc_reg    <= 11'd64;
            yg_reg     <= 3'd2;
            cols_reg   <= 11'd64;
            xg_reg     <= 3'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cddy_pkg::cfg_reg_t'(cfg_index))
                cddy_pkg::REG_METHOD:       method_reg <= cfg_data[0];
                cddy_pkg::REG_POINTS:       ppc_reg    <= cfg_data;
                cddy_pkg::REG_Y_GUARD:      yg_reg     <= cfg_data[2:0];
                cddy_pkg::REG_COLUMN_COUNT: cols_reg   <= cfg_data;
                cddy_pkg::REG_X_GUARD:      xg_reg     <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    cddy_front #(.DATA_WIDTH(DATA_WIDTH), .MAX_POINTS(MAX_POINTS), .NUM_W(NUM_W)) u_front (
        .clk, .rst_n, .accept, .sample, .spacing,
        .method(method_reg), .points_per_column(ppc_reg), .y_guard(yg_reg),
        .column_count(cols_reg), .x_guard(xg_reg),
        .emit(f_emit), .num(f_num), .method_out(f_method), .dy(f_dy),
        .x_idx(f_x), .y_idx(f_y)
    );

    cddy_queue #(.WIDTH(WQ_W)) u_work_q (
        .clk, .rst_n, .wr(f_emit), .wdata({f_num, f_method, f_dy, f_x, f_y}),
        .rd(start), .rdata(wq_out), .nonempty(wq_ne), .count(wq_cnt)
    );

    // start the divider when the result queue has a free slot
    assign start = wq_ne && !busy && (rq_cnt < CW'(cddy_pkg::QUEUE_DEPTH));
    assign take  = done;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bx_reg <= wq_out[2*cddy_pkg::IDX_W-1:cddy_pkg::IDX_W];
            by_reg <= wq_out[cddy_pkg::IDX_W-1:0];
        end
    end

    cddy_back #(.DATA_WIDTH(DATA_WIDTH), .NUM_W(NUM_W)) u_back (
        .clk, .rst_n, .start,
        .num(wq_out[WQ_W-1 -: NUM_W]),
        .method(wq_out[WQ_W-1-NUM_W]),
        .dy(wq_out[2*cddy_pkg::IDX_W +: cddy_pkg::SPACING_W]),
        .take, .busy, .done, .result(b_res), .ovf(b_ovf)
    );

    cddy_queue #(.WIDTH(RQ_W)) u_res_q (
        .clk, .rst_n, .wr(done), .wdata({b_res, b_ovf, bx_reg, by_reg}),
        .rd(pop && rq_ne), .rdata(rq_out), .nonempty(rq_ne), .count(rq_cnt)
    );

    assign empty      = !rq_ne;
    assign derivative = rq_out[RQ_W-1 -: DATA_WIDTH];
    assign overflow   = rq_out[2*cddy_pkg::IDX_W];
    assign x_index    = rq_out[2*cddy_pkg::IDX_W-1:cddy_pkg::IDX_W];
    assign y_index    = rq_out[cddy_pkg::IDX_W-1:0];
endmodule
`default_nettype wire

/* rtl/cddy_front.sv */
// Front end: sample window, counters, interior test and numerator formation.
`timescale 1ns / 1ps
`default_nettype none
module cddy_front #(
    parameter int DATA_WIDTH = cddy_pkg::DATA_WIDTH_DEF,
    parameter int MAX_POINTS = cddy_pkg::MAX_POINTS_DEF,
    parameter int NUM_W      = DATA_WIDTH + 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic signed [DATA_WIDTH-1:0]      sample,
    input  wire logic [cddy_pkg::SPACING_W-1:0]    spacing,
    input  wire logic                              method,
    input  wire logic [cddy_pkg::SIZE_W-1:0]       points_per_column,
    input  wire logic [cddy_pkg::GUARD_W-1:0]      y_guard,
    input  wire logic [cddy_pkg::SIZE_W-1:0]       column_count,
    input  wire logic [cddy_pkg::GUARD_W-1:0]      x_guard,
    output logic                                   emit,
    output logic signed [NUM_W-1:0]                num,
    output logic                                   method_out,
    output logic [cddy_pkg::SPACING_W-1:0]         dy,
    output logic [cddy_pkg::IDX_W-1:0]             x_idx,
    output logic [cddy_pkg::IDX_W-1:0]             y_idx
);
    localparam int CNT_W = $clog2(MAX_POINTS + 1) + 1;
    localparam int SZ_W  = (CNT_W > cddy_pkg::SIZE_W) ? CNT_W : cddy_pkg::SIZE_W;

    logic signed [DATA_WIDTH-1:0]       win_reg [5];
    logic [cddy_pkg::SPACING_W-1:0]     dly_reg [3];
    logic [CNT_W-1:0]                   row_reg, col_reg;
    logic [SZ_W-1:0]                    ppc, cols, szp, szc;
    logic [cddy_pkg::GUARD_W-1:0]       yg;
    logic [CNT_W-1:0]                   c;
    logic                               inside_pt;
    logic signed [DATA_WIDTH-1:0]       p2, p1, m1, m2;

    // clamp sizes
    always_comb
    begin
        szp = SZ_W'(points_per_column);
        szc = SZ_W'(column_count);
        ppc  = (szp == '0) ? SZ_W'(1) : ((szp > SZ_W'(MAX_POINTS)) ? SZ_W'(MAX_POINTS) : szp);
        cols = (szc == '0) ? SZ_W'(1) : ((szc > SZ_W'(MAX_POINTS)) ? SZ_W'(MAX_POINTS) : szc);
        yg   = (y_guard < 3'd2) ? 3'd2 : y_guard;
        c    = row_reg - CNT_W'(2);
        inside_pt = (row_reg >= CNT_W'(2)) && (c >= CNT_W'(yg))
            && ((SZ_W+1)'(c) + (SZ_W+1)'(yg) < (SZ_W+1)'(ppc))
            && (col_reg >= CNT_W'(x_guard))
            && ((SZ_W+1)'(col_reg) + (SZ_W+1)'(x_guard) < (SZ_W+1)'(cols));
        p2 = sample;
        p1 = win_reg[0];
        m1 = win_reg[2];
        m2 = win_reg[3];
    end

    // window and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++) win_reg[i] <= '0;
            for (int i = 0; i < 3; i++) dly_reg[i] <= '0;
            row_reg <= '0;
            col_reg <= '0;
            emit    <= 1'b0;
        end
        else
        begin
            emit <= accept && inside_pt;
            if (accept)
            begin
                win_reg[0] <= sample;
                for (int i = 1; i < 5; i++) win_reg[i] <= win_reg[i-1];
                dly_reg[0] <= spacing;
                dly_reg[1] <= dly_reg[0];
                dly_reg[2] <= dly_reg[1];
                if ((SZ_W+1)'(row_reg) + (SZ_W+1)'(1) >= (SZ_W+1)'(ppc))
                begin
                    row_reg <= '0;
                    col_reg <= ((SZ_W+1)'(col_reg) + (SZ_W+1)'(1) >= (SZ_W+1)'(cols))
                        ? '0 : col_reg + CNT_W'(1);
                end
                else
                    row_reg <= row_reg + CNT_W'(1);
            end
        end
    end

    // numerator, registered
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (method)
                num <= (NUM_W'(p1) - NUM_W'(m1)) * NUM_W'(8) + NUM_W'(m2) - NUM_W'(p2);
            else
                num <= NUM_W'(p1) - NUM_W'(m1);
            method_out <= method;
            dy    <= dly_reg[1];
            x_idx <= col_reg[cddy_pkg::IDX_W-1:0];
            y_idx <= c[cddy_pkg::IDX_W-1:0];
        end
    end
endmodule
`default_nettype wire

/* rtl/cddy_queue.sv */
// Small queue, used between front and back ends and for the results.
`timescale 1ns / 1ps
`default_nettype none
module cddy_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             rd,
    output logic [WIDTH-1:0]      rdata,
    output logic                  nonempty,
    output logic [$clog2(cddy_pkg::QUEUE_DEPTH):0] count
);
    localparam int AW = $clog2(cddy_pkg::QUEUE_DEPTH);
    logic [WIDTH-1:0] mem_reg [cddy_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;

    assign rdata    = mem_reg[rp_reg];
    assign nonempty = cnt_reg != '0;
    assign count    = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + AW'(1);
            if (rd) rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule
`default_nettype wire

/* rtl/cddy_back.sv */
// Back end: radix-2 restoring divider with saturation, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module cddy_back #(
    parameter int DATA_WIDTH = cddy_pkg::DATA_WIDTH_DEF,
    parameter int NUM_W      = DATA_WIDTH + 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [NUM_W-1:0]       num,
    input  wire logic                          method,
    input  wire logic [cddy_pkg::SPACING_W-1:0] dy,
    input  wire logic                          take,
    output logic                               busy,
    output logic                               done,
    output logic signed [DATA_WIDTH-1:0]       result,
    output logic                               ovf
);
    // dividend = |num| << FRAC_BITS; quotient clipped to QW bits is enough
    localparam int DV_W = NUM_W + cddy_pkg::FRAC_BITS;
    localparam int DN_W = cddy_pkg::SPACING_W + 4;
    localparam int QW   = DATA_WIDTH + 1;
    localparam int SH_W = $clog2(DV_W + 1);

    cddy_pkg::div_state_t state_reg, state_next;
    logic [DV_W-1:0]  rem_reg;   // partial remainder
    logic [DV_W-1:0]  dvd_reg;   // dividend bits still to shift in
    logic [DN_W-1:0]  den_reg;
    logic [QW-1:0]    q_reg;
    logic             qbig_reg, neg_reg, zden_reg, zmag_reg;
    logic [SH_W-1:0]  cnt_reg;
    logic [NUM_W-1:0] mag;
    logic [DN_W-1:0]  den;
    logic [DV_W-1:0]  trial;
    logic [DATA_WIDTH-1:0] lim;
    logic             sat;

    always_comb
    begin
        mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den = method ? (DN_W'(dy) << 3) + (DN_W'(dy) << 2) : DN_W'(dy) << 1;
        trial = {rem_reg[DV_W-2:0], dvd_reg[DV_W-1]};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cddy_pkg::DIV_IDLE: if (start) state_next = cddy_pkg::DIV_RUN;
            cddy_pkg::DIV_RUN:  if (cnt_reg == SH_W'(1)) state_next = cddy_pkg::DIV_DONE;
            cddy_pkg::DIV_DONE: if (take) state_next = cddy_pkg::DIV_IDLE;
            default:            state_next = cddy_pkg::DIV_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy = state_reg != cddy_pkg::DIV_IDLE;
        done = state_reg == cddy_pkg::DIV_DONE;
        lim  = neg_reg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        sat  = qbig_reg || (q_reg > QW'(lim));
        if (zden_reg)
        begin
            result = zmag_reg ? '0 : (neg_reg ? lim : lim);
            ovf    = 1'b1;
        end
        else if (sat)
        begin
            result = lim;
            ovf    = 1'b1;
        end
        else
        begin
            result = neg_reg ? DATA_WIDTH'(-q_reg) : q_reg[DATA_WIDTH-1:0];
            ovf    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= cddy_pkg::DIV_IDLE;
        else        state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cddy_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    rem_reg  <= '0;
                    dvd_reg  <= DV_W'(mag) << cddy_pkg::FRAC_BITS;
                    den_reg  <= den;
                    q_reg    <= '0;
                    qbig_reg <= 1'b0;
                    neg_reg  <= num[NUM_W-1];
                    zden_reg <= den == '0;
                    zmag_reg <= mag == '0;
                    cnt_reg  <= SH_W'(DV_W);
                end
            end
            cddy_pkg::DIV_RUN:
            begin
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg - SH_W'(1);
                qbig_reg <= qbig_reg | q_reg[QW-1];
                if (trial >= DV_W'(den_reg))
                begin
                    rem_reg <= trial - DV_W'(den_reg);
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[QW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/cddy_checker.sv */
// Port-level checks for the y-derivative core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cddy_checker #(
    parameter int DATA_WIDTH = cddy_pkg::DATA_WIDTH_DEF
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         full,
    input wire logic                         empty,
    input wire logic                         pop,
    input wire logic signed [DATA_WIDTH-1:0] derivative,
    input wire logic                         overflow
);
    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // a waiting result holds until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(derivative) && $stable(overflow)))
        else $error("result changed while waiting");

    // a flagged result is a saturation limit, or zero for a zero numerator
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && overflow) |->
            (derivative == MAX_POS || derivative == MIN_NEG || derivative == '0))
        else $error("flagged result is not a limit value");

    // nothing can reach the result side in the cycle after reset release
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result present straight after reset");

    // while in reset both queues read as drained
    a_idle: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queue flags wrong during reset");
endmodule

bind central_difference_derivative_y_core cddy_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cddy_checker (
    .clk, .rst_n, .full, .empty, .pop, .derivative, .overflow
);
`default_nettype wire
